// ----- sv/greedy_iou_box_tracker_macros.svh -----
// Assertion macros for the tracker's RTL.
`ifndef GREEDY_IOU_BOX_TRACKER_MACROS_SVH
`define GREEDY_IOU_BOX_TRACKER_MACROS_SVH

// Checked at every clock edge outside reset.
`define GIBT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define GIBT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/gibt_pkg.sv -----
// ----------------------------------------------------------------------------
// Greedy IoU box tracker package
// Widths, reset values, register indexes and record types of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package gibt_pkg;

   localparam int MaxDetDefault = 32;
   localparam int CoordW        = 16;
   localparam int ScoreW        = 16;
   localparam int IdW           = 32;
   localparam int IouW          = 17;
   localparam int CsrAddrW      = 3;
   localparam int CsrDataW      = 32;

   localparam logic [ScoreW-1:0] ThreshReset = 16'd26214;
   localparam logic [IdW-1:0]    IdReset     = 32'd1;

   localparam logic CsrRegThreshold = 1'b0;

   typedef struct packed {
      logic [CoordW-1:0] height;
      logic [CoordW-1:0] width;
      logic [CoordW-1:0] center_y;
      logic [CoordW-1:0] center_x;
   } geo_type;

   typedef struct packed {
      logic [ScoreW-1:0] score;
      geo_type           geo;
   } det_type;

   typedef struct packed {
      logic [IdW-1:0]    ident;
      logic [ScoreW-1:0] score;
      geo_type           geo;
   } trk_type;

endpackage

`default_nettype wire

// ----- sv/greedy_iou_box_tracker.sv -----
// ----------------------------------------------------------------------------
// Greedy IoU box tracker
// Buffers one frame of detection boxes, matches stored tracks to them by
// greatest IoU and emits the new track list.
//
//   Channel  Dir  Handshake             Beat
//   req      in   req_valid/req_stall   one detection or frame marker
//   rsp      out  rsp_valid/rsp_stall   one track of the frame's list
//   csr      in   APB write/read        match_threshold
//
// A detection beat is taken while the tracker is idle. A frame end stalls
// requests until its list is emitted: each IoU runs three arithmetic stages,
// a restoring divider and a compare.
// Reset is synchronous and needs no clearing pass. A stalled result holds the
// output register; the list is read back from the track RAM as it drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "greedy_iou_box_tracker_macros.svh"

module greedy_iou_box_tracker #(
   parameter int MAX_DET = gibt_pkg::MaxDetDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_center_x,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_center_y,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_box_width,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_box_height,
   input  wire logic [gibt_pkg::ScoreW-1:0]   req_confidence,
   input  wire logic                          req_frame_end,
   input  wire logic                          req_no_detection,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_track_valid,
   output      logic [gibt_pkg::IdW-1:0]      rsp_track_number,
   output      logic [gibt_pkg::CoordW-1:0]   rsp_out_center_x,
   output      logic [gibt_pkg::CoordW-1:0]   rsp_out_center_y,
   output      logic [gibt_pkg::CoordW-1:0]   rsp_out_width,
   output      logic [gibt_pkg::CoordW-1:0]   rsp_out_height,
   output      logic [gibt_pkg::ScoreW-1:0]   rsp_out_confidence,
   output      logic                          rsp_list_end,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [gibt_pkg::CsrAddrW-1:0] csr_paddr,
   input  wire logic [gibt_pkg::CsrDataW-1:0] csr_pwdata,
   output      logic [gibt_pkg::CsrDataW-1:0] csr_prdata,
   output      logic                          csr_pready
);

   localparam int AW = (MAX_DET > 1) ? $clog2(MAX_DET) : 1;
   localparam int CW = $clog2(MAX_DET + 1);
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_DET);
   localparam int TrkW = $bits(gibt_pkg::trk_type);
   localparam int DetW = $bits(gibt_pkg::det_type);

   typedef enum logic [3:0] {
      S_IDLE, S_TRK_RD, S_TRK_LD, S_DET_NEXT, S_DET_LD, S_MUL, S_UNI, S_DIV,
      S_CMP, S_BEST_RD, S_BEST_WR, S_NEW_NEXT, S_NEW_WR, S_EMIT_RD, S_EMIT_LD
   } state_type;

   state_type                   state_ff, state_in;
   logic [gibt_pkg::ScoreW-1:0] thr_ff, thr_in;
   logic [CW-1:0]               det_cnt_ff, det_cnt_in;
   logic [CW-1:0]               trk_cnt_ff, trk_cnt_in;
   logic [gibt_pkg::IdW-1:0]    id_ff, id_in;
   logic [CW-1:0]               t_ff, t_in;
   logic [CW-1:0]               n_ff, n_in;
   logic [CW-1:0]               d_ff, d_in;
   logic [AW-1:0]               best_d_ff, best_d_in;
   logic [gibt_pkg::IouW-1:0]   best_ff, best_in;
   logic                        found_ff, found_in;
   logic [MAX_DET-1:0]          claimed_ff, claimed_in;
   gibt_pkg::geo_type           trk_geo_ff, trk_geo_in;
   logic [gibt_pkg::IdW-1:0]    trk_id_ff, trk_id_in;
   logic [15:0]                 bw_ff, bw_in, bh_ff, bh_in;
   logic [17:0]                 dx_ff, dx_in, dy_ff, dy_in;
   logic                        ovl_ff, ovl_in;
   logic [35:0]                 inter_ff, inter_in;
   logic [31:0]                 area_a_ff, area_a_in, area_b_ff, area_b_in;
   logic [35:0]                 uni_ff, uni_in;
   logic [36:0]                 rem_ff, rem_in;
   logic [gibt_pkg::IouW-1:0]   q_ff, q_in;
   logic [4:0]                  bit_ff, bit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   gibt_pkg::trk_type           rsp_trk_ff, rsp_trk_in;
   logic                        rsp_tv_ff, rsp_tv_in;
   logic                        rsp_end_ff, rsp_end_in;

   logic              req_accept;
   logic              out_free;
   logic              load_out;
   logic              csr_write;
   logic              det_we, det_re, trk_we, trk_re;
   logic [AW-1:0]     det_wa, det_ra, trk_wa, trk_ra;
   gibt_pkg::det_type det_wd, det_rd;
   gibt_pkg::trk_type trk_wd, trk_rd;
   logic [CW-1:0]     t_nx;
   logic signed [18:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
   logic signed [18:0] x1, x2, y1, y2, ddx, ddy;
   logic              ge;
   logic [36:0]       rem_sub;

   gibt_ram #(.Width(DetW), .Depth(MAX_DET)) u_det_ram (
      .clock   (clock),
      .wr_en   (det_we),
      .wr_addr (det_wa),
      .wr_data (det_wd),
      .rd_en   (det_re),
      .rd_addr (det_ra),
      .rd_data (det_rd)
   );

   gibt_ram #(.Width(TrkW), .Depth(MAX_DET)) u_trk_ram (
      .clock   (clock),
      .wr_en   (trk_we),
      .wr_addr (trk_wa),
      .wr_data (trk_wd),
      .rd_en   (trk_re),
      .rd_addr (trk_ra),
      .rd_data (trk_rd)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign t_nx       = t_ff + 1'b1;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == gibt_pkg::CsrRegThreshold) ?
                       {16'd0, thr_ff} : '0;

   always_comb begin
      ax1 = $signed({2'b0, trk_geo_ff.center_x, 1'b0}) - $signed({3'b0, trk_geo_ff.width});
      ax2 = $signed({2'b0, trk_geo_ff.center_x, 1'b0}) + $signed({3'b0, trk_geo_ff.width});
      ay1 = $signed({2'b0, trk_geo_ff.center_y, 1'b0}) - $signed({3'b0, trk_geo_ff.height});
      ay2 = $signed({2'b0, trk_geo_ff.center_y, 1'b0}) + $signed({3'b0, trk_geo_ff.height});
      bx1 = $signed({2'b0, det_rd.geo.center_x, 1'b0}) - $signed({3'b0, det_rd.geo.width});
      bx2 = $signed({2'b0, det_rd.geo.center_x, 1'b0}) + $signed({3'b0, det_rd.geo.width});
      by1 = $signed({2'b0, det_rd.geo.center_y, 1'b0}) - $signed({3'b0, det_rd.geo.height});
      by2 = $signed({2'b0, det_rd.geo.center_y, 1'b0}) + $signed({3'b0, det_rd.geo.height});
      x1  = (ax1 > bx1) ? ax1 : bx1;
      x2  = (ax2 < bx2) ? ax2 : bx2;
      y1  = (ay1 > by1) ? ay1 : by1;
      y2  = (ay2 < by2) ? ay2 : by2;
      ddx = x2 - x1;
      ddy = y2 - y1;
      ge      = (rem_ff >= {1'b0, uni_ff});
      rem_sub = ge ? (rem_ff - {1'b0, uni_ff}) : rem_ff;
   end

   always_comb begin
      state_in   = state_ff;
      thr_in     = thr_ff;
      det_cnt_in = det_cnt_ff;
      trk_cnt_in = trk_cnt_ff;
      id_in      = id_ff;
      t_in       = t_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      best_d_in  = best_d_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      claimed_in = claimed_ff;
      trk_geo_in = trk_geo_ff;
      trk_id_in  = trk_id_ff;
      bw_in      = bw_ff;
      bh_in      = bh_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      ovl_in     = ovl_ff;
      inter_in   = inter_ff;
      area_a_in  = area_a_ff;
      area_b_in  = area_b_ff;
      uni_in     = uni_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      bit_in     = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_trk_in   = rsp_trk_ff;
      rsp_tv_in    = rsp_tv_ff;
      rsp_end_in   = rsp_end_ff;
      load_out   = 1'b0;
      det_we     = 1'b0;
      det_wa     = det_cnt_ff[AW-1:0];
      det_wd     = '{score: req_confidence,
                     geo: '{height: req_box_height, width: req_box_width,
                            center_y: req_center_y, center_x: req_center_x}};
      det_re     = 1'b0;
      det_ra     = d_ff[AW-1:0];
      trk_we     = 1'b0;
      trk_wa     = n_ff[AW-1:0];
      trk_wd     = '{ident: trk_id_ff, score: det_rd.score, geo: det_rd.geo};
      trk_re     = 1'b0;
      trk_ra     = t_ff[AW-1:0];

      if (csr_write && (csr_paddr[2] == gibt_pkg::CsrRegThreshold)) begin
         thr_in = csr_pwdata[gibt_pkg::ScoreW-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (!req_no_detection && (det_cnt_ff < MaxCnt)) begin
                  det_we     = 1'b1;
                  det_cnt_in = det_cnt_ff + 1'b1;
               end
               if (req_frame_end) begin
                  t_in     = '0;
                  n_in     = '0;
                  d_in     = '0;
                  state_in = (trk_cnt_ff != '0) ? S_TRK_RD : S_NEW_NEXT;
               end
            end
         end
         S_TRK_RD: begin
            trk_re   = 1'b1;
            state_in = S_TRK_LD;
         end
         S_TRK_LD: begin
            trk_geo_in = trk_rd.geo;
            trk_id_in  = trk_rd.ident;
            d_in       = '0;
            found_in   = 1'b0;
            best_in    = '0;
            state_in   = S_DET_NEXT;
         end
         S_DET_NEXT: begin
            if (d_ff >= det_cnt_ff) begin
               if (found_ff) begin
                  state_in = S_BEST_RD;
               end else begin
                  t_in     = t_nx;
                  d_in     = '0;
                  state_in = (t_nx < trk_cnt_ff) ? S_TRK_RD : S_NEW_NEXT;
               end
            end else if (claimed_ff[d_ff[AW-1:0]]) begin
               d_in = d_ff + 1'b1;
            end else begin
               det_re   = 1'b1;
               state_in = S_DET_LD;
            end
         end
         S_DET_LD: begin
            ovl_in   = !((x2 < x1) || (y2 < y1));
            dx_in    = ddx[17:0];
            dy_in    = ddy[17:0];
            bw_in    = det_rd.geo.width;
            bh_in    = det_rd.geo.height;
            state_in = S_MUL;
         end
         S_MUL: begin
            inter_in  = ovl_ff ? (dx_ff * dy_ff) : '0;
            area_a_in = trk_geo_ff.width * trk_geo_ff.height;
            area_b_in = bw_ff * bh_ff;
            state_in  = S_UNI;
         end
         S_UNI: begin
            uni_in   = {2'b0, area_a_ff, 2'b0} + {2'b0, area_b_ff, 2'b0} - inter_ff;
            rem_in   = {1'b0, inter_ff};
            q_in     = '0;
            bit_in   = 5'd16;
            state_in = S_DIV;
         end
         S_DIV: begin
            q_in   = {q_ff[gibt_pkg::IouW-2:0], ge};
            rem_in = {rem_sub[35:0], 1'b0};
            if (bit_ff == 5'd0) begin
               state_in = S_CMP;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         S_CMP: begin
            if ((uni_ff != '0) && (q_ff > best_ff) && (q_ff > {1'b0, thr_ff})) begin
               best_in   = q_ff;
               best_d_in = d_ff[AW-1:0];
               found_in  = 1'b1;
            end
            d_in     = d_ff + 1'b1;
            state_in = S_DET_NEXT;
         end
         S_BEST_RD: begin
            det_re   = 1'b1;
            det_ra   = best_d_ff;
            state_in = S_BEST_WR;
         end
         S_BEST_WR: begin
            trk_we                = 1'b1;
            claimed_in[best_d_ff] = 1'b1;
            n_in                  = n_ff + 1'b1;
            t_in                  = t_nx;
            d_in                  = '0;
            state_in              = (t_nx < trk_cnt_ff) ? S_TRK_RD : S_NEW_NEXT;
         end
         S_NEW_NEXT: begin
            if ((d_ff >= det_cnt_ff) || (n_ff >= MaxCnt)) begin
               trk_cnt_in = n_ff;
               det_cnt_in = '0;
               claimed_in = '0;
               t_in       = '0;
               state_in   = S_EMIT_RD;
            end else if (claimed_ff[d_ff[AW-1:0]]) begin
               d_in = d_ff + 1'b1;
            end else begin
               det_re   = 1'b1;
               state_in = S_NEW_WR;
            end
         end
         S_NEW_WR: begin
            trk_we   = 1'b1;
            trk_wd   = '{ident: id_ff, score: det_rd.score, geo: det_rd.geo};
            id_in    = id_ff + 1'b1;
            n_in     = n_ff + 1'b1;
            d_in     = d_ff + 1'b1;
            state_in = S_NEW_NEXT;
         end
         S_EMIT_RD: begin
            if (out_free) begin
               if (trk_cnt_ff == '0) begin
                  load_out     = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_trk_in   = '0;
                  rsp_tv_in    = 1'b0;
                  rsp_end_in   = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  trk_re   = 1'b1;
                  state_in = S_EMIT_LD;
               end
            end
         end
         S_EMIT_LD: begin
            load_out     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_trk_in   = trk_rd;
            rsp_tv_in    = 1'b1;
            rsp_end_in   = (t_nx == trk_cnt_ff);
            t_in         = t_nx;
            state_in     = (t_nx == trk_cnt_ff) ? S_IDLE : S_EMIT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= gibt_pkg::ThreshReset;
         det_cnt_ff   <= '0;
         trk_cnt_ff   <= '0;
         id_ff        <= gibt_pkg::IdReset;
         t_ff         <= '0;
         n_ff         <= '0;
         d_ff         <= '0;
         found_ff     <= 1'b0;
         claimed_ff   <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         det_cnt_ff   <= det_cnt_in;
         trk_cnt_ff   <= trk_cnt_in;
         id_ff        <= id_in;
         t_ff         <= t_in;
         n_ff         <= n_in;
         d_ff         <= d_in;
         found_ff     <= found_in;
         claimed_ff   <= claimed_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_d_ff  <= best_d_in;
      best_ff    <= best_in;
      trk_geo_ff <= trk_geo_in;
      trk_id_ff  <= trk_id_in;
      bw_ff      <= bw_in;
      bh_ff      <= bh_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      ovl_ff     <= ovl_in;
      inter_ff   <= inter_in;
      area_a_ff  <= area_a_in;
      area_b_ff  <= area_b_in;
      uni_ff     <= uni_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      rsp_trk_ff <= rsp_trk_in;
      rsp_tv_ff  <= rsp_tv_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_track_valid    = rsp_tv_ff;
   assign rsp_track_number   = rsp_trk_ff.ident;
   assign rsp_out_center_x   = rsp_trk_ff.geo.center_x;
   assign rsp_out_center_y   = rsp_trk_ff.geo.center_y;
   assign rsp_out_width      = rsp_trk_ff.geo.width;
   assign rsp_out_height     = rsp_trk_ff.geo.height;
   assign rsp_out_confidence = rsp_trk_ff.score;
   assign rsp_list_end       = rsp_end_ff;

   `GIBT_ASSERT_ALWAYS(a_pready, csr_pready, "Register port not ready.")
   `GIBT_ASSERT(a_det_bound, det_cnt_ff <= MaxCnt, "Detection count exceeds capacity.")
   `GIBT_ASSERT(a_claim_idle, (state_ff == S_IDLE) |-> (claimed_ff == '0), "Claims left set.")
   `GIBT_ASSERT(a_load_free, load_out |-> !(rsp_valid_ff && rsp_stall), "Result overwritten.")
   `GIBT_ASSERT(a_list_order, (state_ff == S_DET_NEXT) |-> (n_ff <= t_ff), "List passes tracks.")

endmodule

`default_nettype wire

// ----- sv/gibt_ram.sv -----
// ----------------------------------------------------------------------------
// Tracker RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gibt_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output      logic [Width-1:0]                            rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- bench/tracker_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker scoreboard
// Watches the detection, track and register ports of the box tracker, keeps
// its own copy of the track state, predicts each frame's track list and
// compares every track beat against it in order.
// ----------------------------------------------------------------------------

module tracker_scoreboard (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_center_x,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_center_y,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_box_width,
   input  wire logic [gibt_pkg::CoordW-1:0]   req_box_height,
   input  wire logic [gibt_pkg::ScoreW-1:0]   req_confidence,
   input  wire logic                          req_frame_end,
   input  wire logic                          req_no_detection,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          rsp_track_valid,
   input  wire logic [gibt_pkg::IdW-1:0]      rsp_track_number,
   input  wire logic [gibt_pkg::CoordW-1:0]   rsp_out_center_x,
   input  wire logic [gibt_pkg::CoordW-1:0]   rsp_out_center_y,
   input  wire logic [gibt_pkg::CoordW-1:0]   rsp_out_width,
   input  wire logic [gibt_pkg::CoordW-1:0]   rsp_out_height,
   input  wire logic [gibt_pkg::ScoreW-1:0]   rsp_out_confidence,
   input  wire logic                          rsp_list_end,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [gibt_pkg::CsrAddrW-1:0] csr_paddr,
   input  wire logic [gibt_pkg::CsrDataW-1:0] csr_pwdata,
   input  wire logic                          csr_pready,
   output int                                 failures,
   output int                                 outstanding
);

   localparam int Slots = gibt_pkg::MaxDetDefault;
   localparam int Depth = 256;
   localparam int AddrW = gibt_pkg::CsrAddrW;
   localparam logic [AddrW-1:0] ThreshAddr = AddrW'(4 * int'(gibt_pkg::CsrRegThreshold));

   typedef struct packed {
      logic                        present;
      logic [gibt_pkg::IdW-1:0]    ident;
      gibt_pkg::geo_type           geo;
      logic [gibt_pkg::ScoreW-1:0] score;
      logic                        last;
   } beat_type;

   beat_type                    expected_beats[Depth];
   int                          head;
   int                          pending;
   gibt_pkg::geo_type           trk_geo[Slots];
   logic [gibt_pkg::ScoreW-1:0] trk_score[Slots];
   logic [gibt_pkg::IdW-1:0]    trk_ident[Slots];
   int                          trk_count;
   gibt_pkg::geo_type           det_geo[Slots];
   logic [gibt_pkg::ScoreW-1:0] det_score[Slots];
   int                          det_count;
   logic [gibt_pkg::IdW-1:0]    next_ident;
   logic [gibt_pkg::ScoreW-1:0] threshold;

   function automatic longint iou_q16(gibt_pkg::geo_type a, gibt_pkg::geo_type b);
      longint ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, x1, x2, y1, y2, inter, uni;
      ax1 = 2 * longint'(a.center_x) - longint'(a.width);
      ax2 = 2 * longint'(a.center_x) + longint'(a.width);
      ay1 = 2 * longint'(a.center_y) - longint'(a.height);
      ay2 = 2 * longint'(a.center_y) + longint'(a.height);
      bx1 = 2 * longint'(b.center_x) - longint'(b.width);
      bx2 = 2 * longint'(b.center_x) + longint'(b.width);
      by1 = 2 * longint'(b.center_y) - longint'(b.height);
      by2 = 2 * longint'(b.center_y) + longint'(b.height);
      x1 = (ax1 > bx1) ? ax1 : bx1;
      y1 = (ay1 > by1) ? ay1 : by1;
      x2 = (ax2 < bx2) ? ax2 : bx2;
      y2 = (ay2 < by2) ? ay2 : by2;
      if (x2 < x1 || y2 < y1) return 0;
      inter = (x2 - x1) * (y2 - y1);
      uni = 4 * longint'(a.width) * longint'(a.height)
          + 4 * longint'(b.width) * longint'(b.height) - inter;
      if (uni == 0) return 0;
      return (inter << 16) / uni;
   endfunction

   task automatic queue_beat(beat_type b);
      expected_beats[(head + pending) % Depth] = b;
      pending++;
   endtask

   task automatic close_frame();
      gibt_pkg::geo_type           new_geo[Slots];
      logic [gibt_pkg::ScoreW-1:0] new_score[Slots];
      logic [gibt_pkg::IdW-1:0]    new_ident[Slots];
      bit                          claimed[Slots];
      int                          n;
      longint                      best, v;
      int                          best_d;
      beat_type                    beat;
      n = 0;
      foreach (claimed[i]) claimed[i] = 1'b0;
      for (int t = 0; t < trk_count; t++) begin
         best = 0;
         best_d = -1;
         for (int d = 0; d < det_count; d++) begin
            if (!claimed[d]) begin
               v = iou_q16(trk_geo[t], det_geo[d]);
               if (v > best && v > longint'(threshold)) begin
                  best = v;
                  best_d = d;
               end
            end
         end
         if (best_d >= 0 && n < Slots) begin
            claimed[best_d] = 1'b1;
            new_geo[n] = det_geo[best_d];
            new_score[n] = det_score[best_d];
            new_ident[n] = trk_ident[t];
            n++;
         end
      end
      for (int d = 0; d < det_count && n < Slots; d++) begin
         if (!claimed[d]) begin
            new_geo[n] = det_geo[d];
            new_score[n] = det_score[d];
            new_ident[n] = next_ident;
            next_ident = next_ident + 1'b1;
            n++;
         end
      end
      for (int t = 0; t < n; t++) begin
         trk_geo[t] = new_geo[t];
         trk_score[t] = new_score[t];
         trk_ident[t] = new_ident[t];
         beat = '{1'b1, new_ident[t], new_geo[t], new_score[t], t == n - 1};
         queue_beat(beat);
      end
      if (n == 0) queue_beat('{1'b0, '0, '0, '0, 1'b1});
      trk_count = n;
      det_count = 0;
   endtask

   always @(posedge clock) begin
      beat_type got, want;
      if (reset) begin
         head = 0;
         pending = 0;
         failures = 0;
         trk_count = 0;
         det_count = 0;
         next_ident = gibt_pkg::IdReset;
         threshold = gibt_pkg::ThreshReset;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_track_valid, rsp_track_number,
                    '{rsp_out_height, rsp_out_width, rsp_out_center_y, rsp_out_center_x},
                    rsp_out_confidence, rsp_list_end};
            if (pending == 0) begin
               failures++;
               $display("%0t: unexpected track beat, expected none, actual valid=%b id=%0d",
                        $time, got.present, got.ident);
            end else begin
               want = expected_beats[head];
               head = (head + 1) % Depth;
               pending--;
               if (got !== want) begin
                  failures++;
                  $display({"%0t: track mismatch expected valid=%b id=%0d x=%0d y=%0d",
                            " w=%0d h=%0d s=%0d last=%b"},
                           $time, want.present, want.ident, want.geo.center_x,
                           want.geo.center_y, want.geo.width, want.geo.height,
                           want.score, want.last);
                  $display({"%0t:                actual valid=%b id=%0d x=%0d y=%0d",
                            " w=%0d h=%0d s=%0d last=%b"},
                           $time, got.present, got.ident, got.geo.center_x,
                           got.geo.center_y, got.geo.width, got.geo.height,
                           got.score, got.last);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ThreshAddr)
            threshold = csr_pwdata[gibt_pkg::ScoreW-1:0];
         if (req_valid && !req_stall) begin
            if (!req_no_detection && det_count < Slots) begin
               det_geo[det_count] = '{req_box_height, req_box_width, req_center_y,
                                      req_center_x};
               det_score[det_count] = req_confidence;
               det_count++;
            end
            if (req_frame_end) close_frame();
         end
      end
      outstanding = pending;
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box tracker testbench
// Sends frames of detection boxes, many of them near copies of the previous
// frame so that tracks carry over, under several match thresholds and with
// random gaps and stalls. A scoreboard beside the tracker checks each beat.
// ----------------------------------------------------------------------------

module tb;

   localparam int AddrW = gibt_pkg::CsrAddrW;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [gibt_pkg::CoordW-1:0]   req_center_x = '0;
   logic [gibt_pkg::CoordW-1:0]   req_center_y = '0;
   logic [gibt_pkg::CoordW-1:0]   req_box_width = '0;
   logic [gibt_pkg::CoordW-1:0]   req_box_height = '0;
   logic [gibt_pkg::ScoreW-1:0]   req_confidence = '0;
   logic                          req_frame_end = 1'b0;
   logic                          req_no_detection = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_track_valid;
   logic [gibt_pkg::IdW-1:0]      rsp_track_number;
   logic [gibt_pkg::CoordW-1:0]   rsp_out_center_x;
   logic [gibt_pkg::CoordW-1:0]   rsp_out_center_y;
   logic [gibt_pkg::CoordW-1:0]   rsp_out_width;
   logic [gibt_pkg::CoordW-1:0]   rsp_out_height;
   logic [gibt_pkg::ScoreW-1:0]   rsp_out_confidence;
   logic                          rsp_list_end;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [gibt_pkg::CsrAddrW-1:0] csr_paddr = '0;
   logic [gibt_pkg::CsrDataW-1:0] csr_pwdata = '0;
   logic [gibt_pkg::CsrDataW-1:0] csr_prdata;
   logic                          csr_pready;
   int                            failures;
   int                            outstanding;
   bit                            calm = 1'b0;
   int                            stall_left = 0;
   int                            sent = 0;
   gibt_pkg::geo_type             last_boxes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   greedy_iou_box_tracker DUT (.*);
   tracker_scoreboard board (.*);

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= stall_left > 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 15);
         rsp_stall <= 1'b1;
      end
   end

   task automatic send_beat(gibt_pkg::geo_type g, logic [gibt_pkg::ScoreW-1:0] s, bit fe,
                            bit nodet);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_center_x <= g.center_x;
      req_center_y <= g.center_y;
      req_box_width <= g.width;
      req_box_height <= g.height;
      req_confidence <= s;
      req_frame_end <= fe;
      req_no_detection <= nodet;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_threshold(logic [gibt_pkg::ScoreW-1:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= AddrW'(4 * int'(gibt_pkg::CsrRegThreshold));
      csr_pwdata <= ({$urandom} & ~32'hFFFF) | {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic gibt_pkg::geo_type random_box();
      gibt_pkg::geo_type g;
      if ($urandom_range(0, 4) == 0) begin
         g = {$urandom, $urandom};
      end else begin
         g.center_x = 16'($urandom_range(100, 8000));
         g.center_y = 16'($urandom_range(100, 8000));
         g.width = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(16, 2000));
         g.height = 16'($urandom_range(0, 2000));
      end
      return g;
   endfunction

   function automatic gibt_pkg::geo_type nudge(gibt_pkg::geo_type g);
      g.center_x = g.center_x + 16'($urandom_range(0, 16)) - 16'd8;
      g.center_y = g.center_y + 16'($urandom_range(0, 16)) - 16'd8;
      g.width = g.width + 16'($urandom_range(0, 8)) - 16'd4;
      g.height = g.height + 16'($urandom_range(0, 8)) - 16'd4;
      return g;
   endfunction

   // Each box follows a random one of last frame's boxes with follow_pct
   // percent chance; a marker beat, not the last box, closes the frame now and then.
   task automatic send_frame(int count, int follow_pct);
      gibt_pkg::geo_type boxes[$];
      gibt_pkg::geo_type g;
      bit                marker_close;
      marker_close = $urandom_range(0, 3) == 0;
      for (int i = 0; i < count; i++) begin
         if (last_boxes.size() > 0 && $urandom_range(1, 100) <= follow_pct)
            g = nudge(last_boxes[$urandom_range(0, last_boxes.size() - 1)]);
         else
            g = random_box();
         boxes.push_back(g);
         if ($urandom_range(0, 19) == 0)
            send_beat(random_box(), 16'($urandom), 1'b0, 1'b1);
         send_beat(g, 16'($urandom), !marker_close && i == count - 1, 1'b0);
      end
      if (count == 0 || marker_close) send_beat(random_box(), 16'($urandom), 1'b1, 1'b1);
      last_boxes = boxes;
   endtask

   initial begin
      gibt_pkg::geo_type g;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(random_box(), 16'($urandom), 1'b0, 1'b1);
      send_beat('0, '0, 1'b1, 1'b1);
      send_beat('0, '0, 1'b0, 1'b0);
      send_beat('1, '1, 1'b0, 1'b0);
      g = '{16'd200, 16'd300, 16'd1000, 16'd1000};
      send_beat(g, 16'h1234, 1'b1, 1'b0);
      send_beat(g, 16'h4321, 1'b0, 1'b0);
      send_beat(g, 16'h5555, 1'b0, 1'b0);
      send_beat('1, '1, 1'b0, 1'b0);
      send_beat('0, '0, 1'b1, 1'b1);
      send_beat('0, '0, 1'b1, 1'b1);
      write_threshold(16'hFFFF);
      send_beat(g, 16'h0001, 1'b1, 1'b0);
      send_beat(g, 16'h0002, 1'b0, 1'b0);
      send_beat(nudge(g), 16'h0003, 1'b1, 1'b0);
      write_threshold(16'h0000);
      send_beat(nudge(g), 16'hFFFF, 1'b0, 1'b0);
      send_beat(g, 16'h8000, 1'b1, 1'b0);
      write_threshold(gibt_pkg::ThreshReset);

      last_boxes.delete();
      send_frame(35, 0);
      for (int f = 0; sent < 180; f++) begin
         if (sent > 150) calm = 1'b1;
         if (f % 8 == 7) begin
            case ($urandom_range(0, 3))
               0: write_threshold(16'h0000);
               1: write_threshold(16'hFFFF);
               2: write_threshold(gibt_pkg::ThreshReset);
               default: write_threshold(16'($urandom));
            endcase
         end
         if ($urandom_range(0, 9) == 0) send_frame(0, 0);
         else send_frame($urandom_range(1, 8), 85);
      end

      drain();
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
